// ===== design/quadtree_path_codec_core_assert.svh =====
// Assertion macros for the quadtree path codec
`ifndef QUADTREE_PATH_CODEC_CORE_ASSERT_SVH
`define QUADTREE_PATH_CODEC_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define QPC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error("quadtree path codec: same-cycle check failed");
// Next-cycle implication, disabled in reset
`define QPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error("quadtree path codec: next-cycle check failed");
`else
`define QPC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons)
`define QPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== design/qpc_pkg.sv =====
`default_nettype none

package qpc_pkg;

    // Field widths
    localparam int LEVEL_W       = 5;
    localparam int COORD_W       = 24;
    localparam int PATH_W        = 64;
    localparam int LEVEL_FIELD_W = 16;
    localparam int DEEPEST_LEVEL = 24;
    localparam int DIGITS_W      = 2 * COORD_W;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ENCODE  = 2'd0,
        OP_DECODE  = 2'd1,
        OP_CONVERT = 2'd2
    } qpc_op_t;

    // One registered request
    typedef struct packed {
        logic [1:0]         op;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PATH_W-1:0]  path;
    } qpc_req_t;

    // One result
    typedef struct packed {
        logic [PATH_W-1:0]  path;
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               invalid;
    } qpc_res_t;

endpackage

`default_nettype wire

// ===== design/quadtree_path_codec_core.sv =====
// Quadtree path codec core.
// A taken transaction passes the input register and then the result register, which raises done.
// Throughput: one transaction per cycle; busy is always low, so start may be high every cycle.
// The result sits on the ports for one cycle only; the receiver cannot stall.
// Reset: rst_n asynchronous active low clears the input and result valid flags.
`default_nettype none

`include "quadtree_path_codec_core_assert.svh"

module quadtree_path_codec_core
    import qpc_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire [1:0]          op,
    input  wire [LEVEL_W-1:0]  level_in,
    input  wire [COORD_W-1:0]  row_in,
    input  wire [COORD_W-1:0]  col_in,
    input  wire [PATH_W-1:0]   path_in,
    output logic               done,
    output logic [PATH_W-1:0]  path_out,
    output logic [LEVEL_W-1:0] level_out,
    output logic [COORD_W-1:0] row_out,
    output logic [COORD_W-1:0] col_out,
    output logic               invalid
);

    qpc_req_t req_reg;
    qpc_req_t req_next;
    logic     req_valid_reg;
    qpc_res_t res_comb;
    qpc_res_t res_reg;
    logic     res_valid_reg;
    logic     accept;

    // Never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign req_next = '{op: op, level: level_in, row: row_in, col: col_in, path: path_in};

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= accept;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req_next;
    end

    qpc_datapath u_datapath
    (
        .req (req_reg),
        .res (res_comb)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= req_valid_reg;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
            res_reg <= res_comb;
    end

    assign done      = res_valid_reg;
    assign path_out  = res_reg.path;
    assign level_out = res_reg.level;
    assign row_out   = res_reg.row;
    assign col_out   = res_reg.col;
    assign invalid   = res_reg.invalid;

    // Checks
    `QPC_ASSERT_NEXT(a_start_gives_done, clk, rst_n, accept, ##1 done)
    `QPC_ASSERT_NOW(a_invalid_zeroes, clk, rst_n, done && invalid,
        path_out == '0 && level_out == '0 && row_out == '0 && col_out == '0)
    `QPC_ASSERT_NOW(a_level_range, clk, rst_n, done, level_out <= LEVEL_W'(DEEPEST_LEVEL))

endmodule

`default_nettype wire

// ===== design/qpc_datapath.sv =====
`default_nettype none

module qpc_datapath
    import qpc_pkg::*;
(
    input  wire qpc_req_t req,
    output qpc_res_t      res
);

    // Digit vector: digit i (LSB-aligned) pairs row bit i and column bit i
    logic [DIGITS_W-1:0]      enc_digits;
    logic [DIGITS_W-1:0]      dec_digits;
    logic [COORD_W-1:0]       dec_row;
    logic [COORD_W-1:0]       dec_col;
    logic [LEVEL_W:0]         enc_shamt;
    logic [LEVEL_W:0]         path_shamt;
    logic [PATH_W-1:0]        enc_path;
    logic [PATH_W-1:0]        dec_shifted;
    logic [PATH_W-1:0]        used_mask;
    logic [PATH_W-1:0]        conv_path;
    logic                     enc_bad;
    logic                     path_bad;

    // Level checks
    assign enc_bad  = (req.level > LEVEL_W'(DEEPEST_LEVEL));
    assign path_bad = (req.path[LEVEL_FIELD_W-1:0] > LEVEL_FIELD_W'(DEEPEST_LEVEL));

    // Shift that moves the digit field so the used digits fill the top of the path, digit 0 lowest
    assign enc_shamt  = (LEVEL_W+1)'(2 * DEEPEST_LEVEL) - {req.level, 1'b0};
    assign path_shamt = (LEVEL_W+1)'(2 * DEEPEST_LEVEL) - {req.path[LEVEL_W-1:0], 1'b0};

    // Encode: digit high bit is row, low bit is row ^ col
    always_comb
    begin
        for (int i = 0; i < COORD_W; i++)
        begin
            enc_digits[2*i+1] = req.row[i];
            enc_digits[2*i]   = req.row[i] ^ req.col[i];
        end
    end

    // Digits above the level fall off the top of the shift
    assign enc_path = ({enc_digits, {LEVEL_FIELD_W{1'b0}}} << enc_shamt)
                    | {{(PATH_W-LEVEL_W){1'b0}}, req.level};

    // Decode: right-align the used digits, upper digits read as zero
    assign dec_shifted = req.path >> path_shamt;
    assign dec_digits  = dec_shifted[PATH_W-1:LEVEL_FIELD_W];

    always_comb
    begin
        for (int i = 0; i < COORD_W; i++)
        begin
            dec_row[i] = dec_digits[2*i+1];
            dec_col[i] = dec_digits[2*i+1] ^ dec_digits[2*i];
        end
    end

    // Conversion: within the used digits, a set high bit flips the low bit (2 <-> 3)
    assign used_mask = ~({PATH_W{1'b0}} | ({PATH_W{1'b1}} >> {req.path[LEVEL_W-1:0], 1'b0}));
    assign conv_path = req.path
                     ^ ((req.path >> 1) & used_mask & {(PATH_W/2){2'b01}});

    // Result select
    always_comb
    begin
        res = '0;
        unique case (qpc_op_t'(req.op))
            OP_ENCODE:
            begin
                if (enc_bad)
                    res.invalid = 1'b1;
                else
                    res.path = enc_path;
            end
            OP_DECODE:
            begin
                if (path_bad)
                    res.invalid = 1'b1;
                else
                begin
                    res.level = req.path[LEVEL_W-1:0];
                    res.row   = dec_row;
                    res.col   = dec_col;
                end
            end
            OP_CONVERT:
            begin
                if (path_bad)
                    res.invalid = 1'b1;
                else
                    res.path = conv_path;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
